@@ rtl/pbwd_pkg.sv @@
// shared types and constants for the protobuf wire field decoder
package pbwd_pkg;

   // largest length that a length-delimited field may carry
   localparam int unsigned MAX_MESSAGE_BYTES = 16777216;

   // accumulator keeps bits 0..34 (field number needs bits 3..34), rest folds to a sticky flag
   localparam int ACC_W   = 35;
   localparam int LEFT_W  = 25;
   localparam int IDX_W   = 4;
   localparam logic [IDX_W-1:0] VARINT_LAST_IDX = 4'd9;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   typedef enum logic [2:0] {
      PH_TAG     = 3'd0,
      PH_NUM     = 3'd1,
      PH_LEN     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_SKIPV   = 3'd4,
      PH_SKIPLEN = 3'd5,
      PH_SKIPB   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NUM   = 3'd0,
      KIND_START = 3'd1,
      KIND_BYTE  = 3'd2,
      KIND_OK    = 3'd3,
      KIND_ERR   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      WIRE_VARINT = 3'd0,
      WIRE_FIX64  = 3'd1,
      WIRE_LENDEL = 3'd2,
      WIRE_FIX32  = 3'd5
   } wire_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  field_id;
      logic [31:0] value;
      logic        last_of_run;
   } rsp_beat_type;

   // results caused by one input byte
   typedef struct packed {
      rsp_beat_type beat0;
      rsp_beat_type beat1;
      logic [1:0]   beat_cnt;
   } parse_out_type;

endpackage

@@ rtl/pbwd_parser.sv @@
// wire format parser: state registers and per-byte next state and result logic
module pbwd_parser
   import pbwd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          take,
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   output parse_out_type parse_out
);

   phase_type          phase_ff, phase_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               big_ff, big_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [2:0]         field_ff, field_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic               failed_ff, failed_in;

   logic [6:0]         shamt;
   logic [69:0]        sh_w;
   logic [ACC_W-1:0]   acc_upd;
   logic               big_upd;
   logic               len_big;
   logic [31:0]        fld32;
   logic [2:0]         wire_val;
   logic               data_ev;
   rsp_beat_type       data_beat;
   rsp_beat_type       end_beat;
   logic               end_ok;

   // varint byte placed at 7 * index, bits past 63 dropped
   assign shamt   = {idx_ff, 3'b000} - {3'b000, idx_ff};
   assign sh_w    = {63'd0, data_byte[6:0]} << shamt;
   assign acc_upd = acc_ff | sh_w[ACC_W-1:0];
   assign big_upd = big_ff | (|sh_w[63:ACC_W]);
   assign len_big = big_upd || (acc_upd > ACC_W'(MAX_MESSAGE_BYTES));
   assign fld32   = acc_upd[34:3];
   assign wire_val = acc_upd[2:0];

   // next state and results for one byte
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      big_in    = big_ff;
      idx_in    = idx_ff;
      field_in  = field_ff;
      left_in   = left_ff;
      failed_in = failed_ff;
      data_ev   = 1'b0;
      data_beat = '{kind: KIND_NUM, field_id: field_ff, value: 32'd0, last_of_run: 1'b0};
      if (!failed_ff) begin
         case (phase_ff)
            PH_TAG, PH_NUM, PH_LEN, PH_SKIPV, PH_SKIPLEN: begin
               acc_in = acc_upd;
               big_in = big_upd;
               if (data_byte[7]) begin
                  if (idx_ff == VARINT_LAST_IDX) begin
                     failed_in = 1'b1;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end else begin
                  // varint complete
                  acc_in = '0;
                  big_in = 1'b0;
                  idx_in = '0;
                  case (phase_ff)
                     PH_TAG: begin
                        field_in = (fld32 inside {[32'd1:32'd6]}) ? fld32[2:0] : 3'd0;
                        if (fld32 inside {32'd3, 32'd4}) begin
                           phase_in = PH_LEN;
                        end else if (fld32 inside {[32'd1:32'd6]}) begin
                           phase_in = PH_NUM;
                        end else begin
                           case (wire_val)
                              WIRE_VARINT: phase_in = PH_SKIPV;
                              WIRE_FIX64: begin
                                 phase_in = PH_SKIPB;
                                 left_in  = LEFT_W'(8);
                              end
                              WIRE_LENDEL: phase_in = PH_SKIPLEN;
                              WIRE_FIX32: begin
                                 phase_in = PH_SKIPB;
                                 left_in  = LEFT_W'(4);
                              end
                              default: failed_in = 1'b1;
                           endcase
                        end
                     end
                     PH_NUM: begin
                        data_ev         = 1'b1;
                        data_beat.kind  = KIND_NUM;
                        data_beat.value = acc_upd[31:0];
                        phase_in        = PH_TAG;
                        left_in         = '0;
                     end
                     PH_SKIPV: begin
                        phase_in = PH_TAG;
                        left_in  = '0;
                     end
                     default: begin
                        // length of a bytes field or of a skipped one
                        if (len_big) begin
                           failed_in = 1'b1;
                        end else begin
                           if (phase_ff == PH_LEN) begin
                              data_ev         = 1'b1;
                              data_beat.kind  = KIND_START;
                              data_beat.value = acc_upd[31:0];
                           end
                           if (acc_upd == '0) begin
                              phase_in = PH_TAG;
                              left_in  = '0;
                           end else begin
                              phase_in = (phase_ff == PH_LEN) ? PH_PAYLOAD : PH_SKIPB;
                              left_in  = acc_upd[LEFT_W-1:0];
                           end
                        end
                     end
                  endcase
               end
            end
            PH_PAYLOAD, PH_SKIPB: begin
               if (phase_ff == PH_PAYLOAD) begin
                  data_ev         = 1'b1;
                  data_beat.kind  = KIND_BYTE;
                  data_beat.value = {24'd0, data_byte};
               end
               left_in = (left_ff != '0) ? left_ff - 1'b1 : left_ff;
               if (left_in == '0) begin
                  phase_in = PH_TAG;
                  acc_in   = '0;
                  big_in   = 1'b0;
                  idx_in   = '0;
               end
            end
            default: failed_in = 1'b1;
         endcase
      end

      // end of message closes out and returns to reset state
      end_ok   = !failed_in && phase_in == PH_TAG && idx_in == '0;
      end_beat = '{kind: end_ok ? KIND_OK : KIND_ERR, field_id: 3'd0, value: 32'd0,
                   last_of_run: 1'b1};
      if (last_byte) begin
         phase_in  = PH_TAG;
         acc_in    = '0;
         big_in    = 1'b0;
         idx_in    = '0;
         field_in  = '0;
         left_in   = '0;
         failed_in = 1'b0;
      end

      // pack results in order
      parse_out.beat1 = end_beat;
      if (data_ev) begin
         parse_out.beat0             = data_beat;
         parse_out.beat0.last_of_run = !last_byte;
         parse_out.beat_cnt          = last_byte ? 2'd2 : 2'd1;
      end else begin
         parse_out.beat0    = end_beat;
         parse_out.beat_cnt = last_byte ? 2'd1 : 2'd0;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         acc_ff    <= '0;
         big_ff    <= 1'b0;
         idx_ff    <= '0;
         field_ff  <= '0;
         left_ff   <= '0;
         failed_ff <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         big_ff    <= big_in;
         idx_ff    <= idx_in;
         field_ff  <= field_in;
         left_ff   <= left_in;
         failed_ff <= failed_in;
      end
   end

   // two results only when the second closes the message
   a_two_needs_end: assert property (@(posedge clock) disable iff (reset)
      (parse_out.beat_cnt == 2'd2) |->
         (parse_out.beat1.kind == KIND_OK || parse_out.beat1.kind == KIND_ERR))
      else $error("second result is not an end beat");

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (take && last_byte) |=> (phase_ff == PH_TAG && !failed_ff && idx_ff == '0))
      else $error("state not cleared after last byte");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!failed_ff && (phase_ff == PH_PAYLOAD || phase_ff == PH_SKIPB)) |-> (left_ff != '0))
      else $error("byte run phase with nothing left");

endmodule

@@ rtl/pbwd_rsp_fifo.sv @@
// small result queue taking up to two beats a cycle and giving one while out_ready is high
module pbwd_rsp_fifo
   import pbwd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  parse_out_type push,
   input  logic          push_en,
   output logic          space_ok,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_beat_type  out_beat
);

   rsp_beat_type      mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        push_cnt;
   logic              pop;

   assign push_cnt  = push_en ? push.beat_cnt : 2'd0;
   assign pop       = out_valid && out_ready;
   assign out_valid = count_ff != '0;
   assign out_beat  = mem_ff[rd_ptr_ff];
   assign space_ok  = count_ff <= CNT_W'(FIFO_DEPTH - 2);

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // beat storage
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.beat0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_ff + 1'b1] <= push.beat1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_room_for_two: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> (count_ff <= CNT_W'(FIFO_DEPTH - 2)))
      else $error("push without room for two beats");

endmodule

@@ rtl/protobuf_wire_field_decoder_top.sv @@
// Protobuf wire format decoder: one message byte in per beat, field results out.
// Each accepted byte is parsed in the cycle it is taken and gives zero, one or two result
// beats (a number, a bytes-start with length, a payload byte, then an end ok or end error
// beat on the last byte). Input bytes are taken at one per cycle while the queue has room;
// the results pass through a four-entry queue, so a byte is accepted whenever at least
// two entries are free. A byte that yields two results (only a last byte can) gives them
// out one after the other, so throughput is one byte per cycle while the result side
// keeps up, and the results of a byte are registered in the queue as it is accepted.
module protobuf_wire_field_decoder_top
   import pbwd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_field_id,
   output logic [31:0] rsp_value,
   output logic        rsp_last_of_run
);

   parse_out_type parse_out;
   rsp_beat_type  head_beat;
   logic          take;
   logic          space_ok;

   assign req_ready = space_ok;
   assign take      = req_valid && req_ready;

   // byte parser
   pbwd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .parse_out (parse_out)
   );

   // result queue
   pbwd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (parse_out),
      .push_en   (take),
      .space_ok  (space_ok),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (head_beat)
   );

   assign rsp_kind        = head_beat.kind;
   assign rsp_field_id    = head_beat.field_id;
   assign rsp_value       = head_beat.value;
   assign rsp_last_of_run = head_beat.last_of_run;

endmodule

@@ bench/protobuf_wire_field_decoder_top_tb.sv @@
// self-checking bench for the protobuf wire field decoder: directed table, then random messages
module protobuf_wire_field_decoder_top_tb
   import pbwd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 750;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned FIX64_BYTES  = 8;
   localparam int unsigned FIX32_BYTES  = 4;
   localparam logic [7:0]  CONT_BIT     = 8'h80;

   // how a directed row is checked
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_SILENT,
      ROW_END
   } row_check_type;

   typedef struct packed {
      logic [7:0]    data;
      logic          last;
      row_check_type mode;
      kind_type      kind;
   } dir_row_type;

   // directed bytes: short messages covering every result kind and the error paths
   localparam dir_row_type DIRECTED_ROWS [0:25] = '{
      // field 1 tag and then the message ends
      '{8'h08, 1'b1, ROW_END,     KIND_ERR},
      // field 5 with a one-byte value
      '{8'h28, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h7F, 1'b1, ROW_PREDICT, KIND_NUM},
      // field 3 with a two-byte payload at both byte extremes
      '{8'h1A, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h02, 1'b0, ROW_PREDICT, KIND_NUM},
      '{8'h00, 1'b0, ROW_PREDICT, KIND_NUM},
      '{8'hFF, 1'b1, ROW_PREDICT, KIND_NUM},
      // empty field 4
      '{8'h22, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h00, 1'b1, ROW_PREDICT, KIND_NUM},
      // unknown field with a bad wire type, then a byte that is ignored
      '{8'h3B, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h55, 1'b1, ROW_END,     KIND_ERR},
      // length one above the limit
      '{8'h1A, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h81, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h80, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h80, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h08, 1'b1, ROW_END,     KIND_ERR},
      // tag varint whose tenth byte still has the continuation bit set
      '{8'h80, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h80, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h80, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h80, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h80, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h80, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h80, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h80, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h80, 1'b0, ROW_SILENT,  KIND_NUM},
      '{8'h80, 1'b1, ROW_END,     KIND_ERR}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [2:0]  rsp_field_id;
   logic [31:0] rsp_value;
   logic        rsp_last_of_run;

   // decoder state mirrored by the bench
   phase_type   pb_phase;
   logic [63:0] pb_acc;
   logic [3:0]  pb_idx;
   logic [2:0]  pb_field;
   logic [2:0]  pb_wire;
   logic [31:0] pb_left;
   bit          pb_failed;

   rsp_beat_type step_beats[$];
   rsp_beat_type pending_results[$];
   logic [7:0]   msg_bytes[$];

   int unsigned fail_count;
   int unsigned cycle_count;
   int unsigned beats_checked;
   int unsigned bytes_sent;
   int unsigned parsed_items;
   int unsigned msg_count;
   int unsigned burst_left;
   bit          no_idle;
   int unsigned ready_tick;
   int unsigned ready_style;
   int unsigned stall_left;

   protobuf_wire_field_decoder_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_field_id   (rsp_field_id),
      .rsp_value      (rsp_value),
      .rsp_last_of_run(rsp_last_of_run)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void flag_error(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("ERROR @%0t: %s", $time, msg);
   endfunction

   // ---------------------------------------------------------------- predictor

   function automatic void parse_restart();
      pb_phase = PH_TAG;
      pb_acc   = '0;
      pb_idx   = '0;
      pb_left  = '0;
   endfunction

   function automatic void parse_clear();
      parse_restart();
      pb_field  = '0;
      pb_wire   = '0;
      pb_failed = 1'b0;
   endfunction

   function automatic void add_beat(kind_type k, logic [2:0] f, logic [31:0] v);
      step_beats.push_back('{kind: k, field_id: f, value: v, last_of_run: 1'b0});
   endfunction

   // work out the result beats that one accepted byte causes
   function automatic void parse_byte(logic [7:0] d, logic l);
      logic [31:0] fnum;
      logic [2:0]  wt;
      step_beats.delete();
      if (!pb_failed) begin
         case (pb_phase)
            PH_TAG, PH_NUM, PH_LEN, PH_SKIPV, PH_SKIPLEN: begin
               // base-128 group, bits past 63 fall off
               pb_acc = pb_acc | ({57'd0, d[6:0]} << (7 * pb_idx));
               if (d[7]) begin
                  pb_idx = pb_idx + 4'd1;
                  if (pb_idx > VARINT_LAST_IDX)
                     pb_failed = 1'b1;
               end else begin
                  case (pb_phase)
                     PH_TAG: begin
                        fnum     = pb_acc[34:3];
                        wt       = pb_acc[2:0];
                        pb_acc   = '0;
                        pb_idx   = '0;
                        pb_wire  = wt;
                        pb_field = (fnum inside {[32'd1:32'd6]}) ? fnum[2:0] : 3'd0;
                        if (fnum inside {32'd3, 32'd4}) begin
                           pb_phase = PH_LEN;
                        end else if (pb_field != 3'd0) begin
                           pb_phase = PH_NUM;
                        end else begin
                           // unknown field, skipped by wire type
                           case (wt)
                              WIRE_VARINT: pb_phase = PH_SKIPV;
                              WIRE_FIX64: begin
                                 pb_phase = PH_SKIPB;
                                 pb_left  = FIX64_BYTES;
                              end
                              WIRE_LENDEL: pb_phase = PH_SKIPLEN;
                              WIRE_FIX32: begin
                                 pb_phase = PH_SKIPB;
                                 pb_left  = FIX32_BYTES;
                              end
                              default: pb_failed = 1'b1;
                           endcase
                        end
                     end
                     PH_NUM: begin
                        add_beat(KIND_NUM, pb_field, pb_acc[31:0]);
                        parse_restart();
                     end
                     PH_SKIPV: parse_restart();
                     default: begin
                        // length of a bytes field or of a skipped run
                        if (pb_acc > 64'(MAX_MESSAGE_BYTES)) begin
                           pb_failed = 1'b1;
                        end else begin
                           if (pb_phase == PH_LEN)
                              add_beat(KIND_START, pb_field, pb_acc[31:0]);
                           if (pb_acc == 64'd0) begin
                              parse_restart();
                           end else begin
                              pb_left  = pb_acc[31:0];
                              pb_phase = (pb_phase == PH_LEN) ? PH_PAYLOAD : PH_SKIPB;
                              pb_acc   = '0;
                              pb_idx   = '0;
                           end
                        end
                     end
                  endcase
               end
            end
            PH_PAYLOAD, PH_SKIPB: begin
               if (pb_phase == PH_PAYLOAD)
                  add_beat(KIND_BYTE, pb_field, {24'd0, d});
               if (pb_left > 0)
                  pb_left = pb_left - 1;
               if (pb_left == 0)
                  parse_restart();
            end
            default: pb_failed = 1'b1;
         endcase
      end
      // end of message
      if (l) begin
         if (!pb_failed && pb_phase == PH_TAG && pb_idx == '0)
            add_beat(KIND_OK, 3'd0, 32'd0);
         else
            add_beat(KIND_ERR, 3'd0, 32'd0);
         parse_clear();
      end
      if (step_beats.size() > 0)
         step_beats[step_beats.size()-1].last_of_run = 1'b1;
   endfunction

   // ---------------------------------------------------------------- message builder

   function automatic int unsigned small_pad();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
   endfunction

   function automatic void add_varint(logic [63:0] v, int unsigned pad);
      int unsigned groups;
      int unsigned total;
      logic [63:0] rest;
      logic        cont;
      groups = 1;
      rest   = v >> 7;
      while (rest != 0) begin
         groups++;
         rest = rest >> 7;
      end
      total = groups + pad;
      if (total > 10)
         total = 10;
      rest = v;
      for (int i = 0; i < total; i++) begin
         cont = (i < total - 1);
         msg_bytes.push_back({cont, rest[6:0]});
         rest = rest >> 7;
      end
   endfunction

   function automatic void add_raw(int unsigned n);
      repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // tag of a known field, sometimes with bits above the kept field number
   function automatic logic [63:0] known_tag(logic [31:0] fnum, logic [2:0] wt);
      logic [63:0] hi;
      hi = ($urandom_range(0, 7) == 0) ? {32'd0, $urandom() & 32'h1FFF_FFFF} : 64'd0;
      return ({hi[31:0], fnum} << 3) | {61'd0, wt};
   endfunction

   // tag of a field outside the schema
   function automatic logic [63:0] unknown_tag(logic [2:0] wt);
      logic [63:0] fnum;
      case ($urandom_range(0, 3))
         0:       fnum = 64'd0;
         1:       fnum = 64'($urandom_range(7, 15));
         2:       fnum = {32'd0, $urandom()};
         default: fnum = {$urandom(), $urandom()} >> 3;
      endcase
      if (fnum[31:0] inside {[32'd1:32'd6]})
         fnum = fnum + 64'd6;
      return (fnum << 3) | {61'd0, wt};
   endfunction

   // one random message: mostly well formed fields, some broken ones and noise
   function automatic void build_message();
      int unsigned sel;
      int unsigned cut;
      int unsigned len;
      logic [31:0] fnum;
      logic [2:0]  wt;
      logic [63:0] big;
      msg_bytes.delete();
      repeat ($urandom_range(1, 4)) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            case ($urandom_range(0, 3))
               0:       fnum = 1;
               1:       fnum = 2;
               2:       fnum = 5;
               default: fnum = 6;
            endcase
            wt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : WIRE_VARINT;
            add_varint(known_tag(fnum, wt), small_pad());
            add_varint({$urandom(), $urandom()} >> $urandom_range(0, 63), small_pad());
         end else if (sel < 60) begin
            fnum = $urandom_range(3, 4);
            wt   = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : WIRE_LENDEL;
            len  = $urandom_range(0, 6);
            add_varint(known_tag(fnum, wt), small_pad());
            add_varint(64'(len), small_pad());
            add_raw(len);
         end else if (sel < 85) begin
            case ($urandom_range(0, 3))
               0:       wt = WIRE_VARINT;
               1:       wt = WIRE_FIX64;
               2:       wt = WIRE_LENDEL;
               default: wt = WIRE_FIX32;
            endcase
            add_varint(unknown_tag(wt), small_pad());
            case (wt)
               WIRE_VARINT: add_varint({$urandom(), $urandom()} >> $urandom_range(0, 63),
                                       small_pad());
               WIRE_FIX64:  add_raw(FIX64_BYTES);
               WIRE_LENDEL: begin
                  len = $urandom_range(0, 5);
                  add_varint(64'(len), small_pad());
                  add_raw(len);
               end
               default:     add_raw(FIX32_BYTES);
            endcase
         end else if (sel < 90) begin
            // unknown field with a wire type that cannot be skipped
            case ($urandom_range(0, 3))
               0:       wt = 3'd3;
               1:       wt = 3'd4;
               2:       wt = 3'd6;
               default: wt = 3'd7;
            endcase
            add_varint(unknown_tag(wt), small_pad());
            add_raw($urandom_range(0, 3));
         end else if (sel < 94) begin
            // varint that never ends
            repeat (10) msg_bytes.push_back(CONT_BIT | 8'($urandom_range(0, 127)));
            add_raw($urandom_range(0, 2));
         end else if (sel < 97) begin
            // length at or beyond the limit
            if ($urandom_range(0, 1) == 0)
               add_varint(known_tag($urandom_range(3, 4), WIRE_LENDEL), 0);
            else
               add_varint(unknown_tag(WIRE_LENDEL), 0);
            case ($urandom_range(0, 2))
               0:       big = 64'(MAX_MESSAGE_BYTES) + 1 + $urandom_range(0, 1000);
               1:       big = {$urandom(), $urandom()} | 64'h1_0000_0000;
               default: big = 64'(MAX_MESSAGE_BYTES);
            endcase
            add_varint(big, 0);
            add_raw($urandom_range(0, 3));
         end else begin
            add_raw($urandom_range(1, 6));
         end
      end
      // now and then the message is cut short
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, msg_bytes.size());
         while (msg_bytes.size() > cut)
            void'(msg_bytes.pop_back());
      end
   endfunction

   // ---------------------------------------------------------------- driving

   // send one byte beat, idling between bursts, and predict its results on acceptance
   task automatic send_byte(input logic [7:0] d, input logic l, input bit model_check);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= l;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (!pb_failed)
         parsed_items++;
      parse_byte(d, l);
      if (model_check)
         foreach (step_beats[i]) pending_results.push_back(step_beats[i]);
   endtask

   // hold the sender off until every outstanding result has come out
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver stalls: always ready, random, periodic, or long holds
   always @(negedge clock) begin
      ready_tick++;
      if (ready_tick % 256 == 0)
         ready_style = $urandom_range(0, 3);
      case (ready_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 9) < 7);
         2: rsp_ready <= (ready_tick % 4 != 3);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 12);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_rsp
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (pending_results.size() == 0) begin
            flag_error($sformatf("unexpected result beat kind %0d field %0d value 0x%08h",
                                 rsp_kind, rsp_field_id, rsp_value));
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind || rsp_field_id !== want.field_id ||
                rsp_value !== want.value || rsp_last_of_run !== want.last_of_run)
               flag_error($sformatf({"beat %0d: got kind %0d field %0d value 0x%08h last %0b,",
                                     " expected kind %0d field %0d value 0x%08h last %0b"},
                                    beats_checked, rsp_kind, rsp_field_id, rsp_value,
                                    rsp_last_of_run, want.kind, want.field_id, want.value,
                                    want.last_of_run));
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      parse_clear();
      ready_style = 0;

      // synchronous reset, released at a falling clock edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last,
                   DIRECTED_ROWS[i].mode == ROW_PREDICT);
         if (DIRECTED_ROWS[i].mode == ROW_END)
            pending_results.push_back('{kind: DIRECTED_ROWS[i].kind, field_id: 3'd0,
                                        value: 32'd0, last_of_run: 1'b1});
      end
      drain_results();

      // random messages
      parsed_items = 0;
      while (parsed_items < RANDOM_ITEMS) begin
         build_message();
         no_idle = ($urandom_range(0, 5) == 0);
         foreach (msg_bytes[i])
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b1);
         msg_count++;
         if (msg_count % 40 == 0)
            drain_results();
      end

      // wait for the tail and a little beyond
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         flag_error($sformatf("%0d results never arrived", pending_results.size()));

      $display("run: %0d byte beats sent, %0d random messages, %0d random bytes parsed",
               bytes_sent, msg_count, parsed_items);
      $display("run: %0d result beats checked, %0d errors", beats_checked, fail_count);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
